>>> src/sha1_pkg.sv
// Shared types and constants of the SHA-1 stream hash.
`timescale 1ns / 1ps

package sha1_pkg;

    localparam int WORD_W  = 32;
    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 3;
    localparam int FILL_W  = 6;
    localparam int LEN_W   = 64;
    localparam int ROUND_W = 7;

    typedef logic [WORD_W-1:0]       word_t;
    typedef logic [4:0][WORD_W-1:0]  chain_t;
    typedef logic [15:0][WORD_W-1:0] sched_t;

    localparam logic ACT_ABSORB = 1'b0;
    localparam logic ACT_FINISH = 1'b1;

    localparam chain_t INIT_CHAIN = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam word_t K_ROUND_0 = 32'h5A827999;
    localparam word_t K_ROUND_1 = 32'h6ED9EBA1;
    localparam word_t K_ROUND_2 = 32'h8F1BBCDC;
    localparam word_t K_ROUND_3 = 32'hCA62C1D6;

    localparam logic [BYTE_W-1:0] PAD_BYTE = 8'h80;

    localparam logic [ROUND_W-1:0] ROUND_SCHED = 7'd16;
    localparam logic [ROUND_W-1:0] ROUND_P1    = 7'd20;
    localparam logic [ROUND_W-1:0] ROUND_P2    = 7'd40;
    localparam logic [ROUND_W-1:0] ROUND_P3    = 7'd60;
    localparam logic [ROUND_W-1:0] ROUND_LAST  = 7'd79;

    localparam logic [FILL_W-1:0]  FILL_LAST   = 6'd63;
    localparam logic [INDEX_W-1:0] INDEX_LAST  = 3'd4;

endpackage

>>> src/sha1_in_if.sv
// Input channel of the SHA-1 stream hash: one message byte or a finish command.
`timescale 1ns / 1ps

interface sha1_in_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [sha1_pkg::BYTE_W-1:0] data_byte;

    modport source (output valid, output action, output data_byte, input ready);
    modport sink   (input valid, input action, input data_byte, output ready);
endinterface

>>> src/sha1_out_if.sv
// Output channel of the SHA-1 stream hash: one digest word per transaction.
`timescale 1ns / 1ps

interface sha1_out_if;
    logic                         valid;
    logic                         ready;
    logic [sha1_pkg::WORD_W-1:0]  digest_word;
    logic [sha1_pkg::INDEX_W-1:0] word_index;
    logic                         last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, output ready);
endinterface

>>> src/sha1_stream_hash.sv
// SHA-1 stream hash: byte absorber, padding and one shared round unit.
//
// Usage: each transaction on item carries action and data_byte. Action
// absorb appends data_byte to the message; action finish pads the message,
// compresses the tail and then sends the 160-bit digest on digest as five
// transactions, word_index 0 to 4, most significant word first, last_word
// set on the fifth. The block then starts a fresh message.
// Throughput: an absorb is taken while item.ready is high. The byte that
// fills a 64-byte block starts a compression: one round per cycle through the
// single round adder, 80 rounds and then the chaining add, with item.ready low
// until the chaining add is done. Finish: a padding step and one compression,
// a second when 56 or more bytes are pending, then the five words at one per
// cycle while digest.ready is high. A stalled receiver holds the current digest
// word; no new item is taken until the fifth word is accepted.
// Reset (rst_n low, asynchronous) loads the initial hash words, clears the
// byte count and the length, and leaves the block idle and ready.
`timescale 1ns / 1ps

module sha1_stream_hash (
    input  logic       clk,
    input  logic       rst_n,
    sha1_in_if.sink    item,
    sha1_out_if.source digest
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } state_t;

    state_t                           state_reg, state_next;
    sha1_pkg::chain_t                 chain_reg, chain_next;
    logic [sha1_pkg::FILL_W-1:0]      fill_reg, fill_next;
    logic [sha1_pkg::LEN_W-1:0]       bits_reg, bits_next;
    logic [sha1_pkg::ROUND_W-1:0]     round_reg, round_next;
    logic [sha1_pkg::INDEX_W-1:0]     index_reg, index_next;
    logic                             final_reg, final_next;
    logic                             spill_reg, spill_next;
    sha1_pkg::sched_t                 sched_reg, sched_next;
    sha1_pkg::chain_t                 vars_reg, vars_next;

    sha1_pkg::word_t                  w_mix;
    sha1_pkg::word_t                  w_cur;
    sha1_pkg::word_t                  f_cur;
    sha1_pkg::word_t                  k_cur;
    sha1_pkg::word_t                  temp;
    sha1_pkg::chain_t                 chain_sum;
    logic [sha1_pkg::FILL_W-1:0]      pos;

    // Round unit: schedule word, round function and the five-input add.
    always_comb
    begin
        w_mix = sched_reg[13] ^ sched_reg[8] ^ sched_reg[2] ^ sched_reg[0];
        w_cur = (round_reg < sha1_pkg::ROUND_SCHED) ? sched_reg[0]
                                                   : {w_mix[30:0], w_mix[31]};
        priority if (round_reg < sha1_pkg::ROUND_P1)
        begin
            f_cur = (vars_reg[1] & vars_reg[2]) | (~vars_reg[1] & vars_reg[3]);
            k_cur = sha1_pkg::K_ROUND_0;
        end
        else if (round_reg < sha1_pkg::ROUND_P2)
        begin
            f_cur = vars_reg[1] ^ vars_reg[2] ^ vars_reg[3];
            k_cur = sha1_pkg::K_ROUND_1;
        end
        else if (round_reg < sha1_pkg::ROUND_P3)
        begin
            f_cur = (vars_reg[1] & vars_reg[2]) | (vars_reg[1] & vars_reg[3])
                  | (vars_reg[2] & vars_reg[3]);
            k_cur = sha1_pkg::K_ROUND_2;
        end
        else
        begin
            f_cur = vars_reg[1] ^ vars_reg[2] ^ vars_reg[3];
            k_cur = sha1_pkg::K_ROUND_3;
        end
        temp = {vars_reg[0][26:0], vars_reg[0][31:27]} + f_cur + vars_reg[4]
             + k_cur + w_cur;
        for (int i = 0; i < 5; i++)
        begin
            chain_sum[i] = chain_reg[i] + vars_reg[i];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        chain_next = chain_reg;
        fill_next  = fill_reg;
        bits_next  = bits_reg;
        round_next = round_reg;
        index_next = index_reg;
        final_next = final_reg;
        spill_next = spill_reg;
        sched_next = sched_reg;
        vars_next  = vars_reg;
        pos        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    if (item.action == sha1_pkg::ACT_FINISH)
                    begin
                        state_next = ST_PAD;
                    end
                    else
                    begin
                        sched_next[fill_reg[5:2]][{~fill_reg[1:0], 3'b000} +: 8] =
                            item.data_byte;
                        bits_next = bits_reg + 64'd8;
                        fill_next = fill_reg + 6'd1;
                        if (fill_reg == sha1_pkg::FILL_LAST)
                        begin
                            vars_next  = chain_reg;
                            round_next = '0;
                            state_next = ST_ROUND;
                        end
                    end
                end
            end
            ST_PAD:
            begin
                // Keep bytes below the fill point, mark the end, zero the rest.
                for (int i = 0; i < 16; i++)
                begin
                    for (int j = 0; j < 4; j++)
                    begin
                        pos = 6'(4 * i + j);
                        if (pos == fill_reg)
                        begin
                            sched_next[i][(24 - 8 * j) +: 8] = sha1_pkg::PAD_BYTE;
                        end
                        else if (pos > fill_reg)
                        begin
                            sched_next[i][(24 - 8 * j) +: 8] = '0;
                        end
                    end
                end
                spill_next = (fill_reg[5:3] == 3'b111);
                if (fill_reg[5:3] != 3'b111)
                begin
                    sched_next[14] = bits_reg[63:32];
                    sched_next[15] = bits_reg[31:0];
                end
                final_next = 1'b1;
                vars_next  = chain_reg;
                round_next = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                vars_next  = {vars_reg[3], vars_reg[2],
                              {vars_reg[1][1:0], vars_reg[1][31:2]},
                              vars_reg[0], temp};
                sched_next = {w_cur, sched_reg[15:1]};
                round_next = round_reg + 7'd1;
                if (round_reg == sha1_pkg::ROUND_LAST)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                chain_next = chain_sum;
                if (spill_reg)
                begin
                    sched_next     = '0;
                    sched_next[14] = bits_reg[63:32];
                    sched_next[15] = bits_reg[31:0];
                    vars_next      = chain_sum;
                    round_next     = '0;
                    spill_next     = 1'b0;
                    state_next     = ST_ROUND;
                end
                else if (final_reg)
                begin
                    index_next = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (digest.ready)
                begin
                    chain_next = {chain_reg[4], chain_reg[4:1]};
                    index_next = index_reg + 3'd1;
                    if (index_reg == sha1_pkg::INDEX_LAST)
                    begin
                        chain_next = sha1_pkg::INIT_CHAIN;
                        fill_next  = '0;
                        bits_next  = '0;
                        final_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            chain_reg <= sha1_pkg::INIT_CHAIN;
            fill_reg  <= '0;
            bits_reg  <= '0;
            round_reg <= '0;
            index_reg <= '0;
            final_reg <= 1'b0;
            spill_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            chain_reg <= chain_next;
            fill_reg  <= fill_next;
            bits_reg  <= bits_next;
            round_reg <= round_next;
            index_reg <= index_next;
            final_reg <= final_next;
            spill_reg <= spill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sched_reg <= sched_next;
        vars_reg  <= vars_next;
    end

    assign item.ready         = (state_reg == ST_IDLE);
    assign digest.valid       = (state_reg == ST_OUT);
    assign digest.digest_word = chain_reg[0];
    assign digest.word_index  = index_reg;
    assign digest.last_word   = (index_reg == sha1_pkg::INDEX_LAST);

endmodule
